### hw/rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants of the 3D segment-segment closest distance block.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int COORD_WIDTH_DEF     = 32;
   localparam int PARAM_FRAC_BITS_DEF = 16;
   localparam int FIELD_WIDTH         = 32;
   localparam int DIST_WIDTH          = 33;
   localparam int PARAM_WIDTH         = 17;
   localparam int MUL_CHUNK           = 16;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] first_start_x;
      logic signed [FIELD_WIDTH-1:0] first_start_y;
      logic signed [FIELD_WIDTH-1:0] first_start_z;
      logic signed [FIELD_WIDTH-1:0] first_end_x;
      logic signed [FIELD_WIDTH-1:0] first_end_y;
      logic signed [FIELD_WIDTH-1:0] first_end_z;
      logic signed [FIELD_WIDTH-1:0] second_start_x;
      logic signed [FIELD_WIDTH-1:0] second_start_y;
      logic signed [FIELD_WIDTH-1:0] second_start_z;
      logic signed [FIELD_WIDTH-1:0] second_end_x;
      logic signed [FIELD_WIDTH-1:0] second_end_y;
      logic signed [FIELD_WIDTH-1:0] second_end_z;
   } req_type;

   typedef struct packed {
      logic [DIST_WIDTH-1:0]  closest_distance;
      logic [PARAM_WIDTH-1:0] first_param;
      logic [PARAM_WIDTH-1:0] second_param;
   } rsp_type;

endpackage

### hw/rtl/ssd_mul.sv
// ----------------------------------------------------------------------------
// ssd_mul
// Pipelined signed multiplier lanes: one partial product of A by a chunk of B
// per stage, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module ssd_mul #(
   parameter int N  = 1,
   parameter int WA = 33,
   parameter int WB = 33,
   parameter int WS = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [WS-1:0]               in_side,
   input  logic [N-1:0][WA-1:0]        in_a,
   input  logic [N-1:0][WB-1:0]        in_b,
   output logic                        out_valid,
   output logic [WS-1:0]               out_side,
   output logic [N-1:0][WA+WB-1:0]     out_p
);
   import ssd_pkg::*;

   localparam int NST = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int WP  = WA + WB;

   logic                  vld [NST+1];
   logic [WS-1:0]         sid [NST+1];
   logic [N-1:0][WA-1:0]  opa [NST+1];
   logic [N-1:0][WB-1:0]  opb [NST+1];
   logic [N-1:0][WP-1:0]  acc [NST+1];

   assign vld[0] = in_valid;
   assign sid[0] = in_side;
   assign opa[0] = in_a;
   assign opb[0] = in_b;
   assign acc[0] = '0;

   for (genvar k = 0; k < NST; k++) begin : g_stage
      logic                 vld_ff;
      logic [WS-1:0]        sid_ff;
      logic [N-1:0][WA-1:0] opa_ff;
      logic [N-1:0][WB-1:0] opb_ff;
      logic [N-1:0][WP-1:0] acc_ff;
      logic [N-1:0][WP-1:0] acc_in;

      for (genvar n = 0; n < N; n++) begin : g_lane
         logic signed [MUL_CHUNK:0]    chunk;
         logic signed [WA+MUL_CHUNK:0] pp;
         if (k < NST - 1) begin : g_low
            assign chunk = {1'b0, opb[k][n][MUL_CHUNK*k +: MUL_CHUNK]};
         end else begin : g_top
            assign chunk = (MUL_CHUNK+1)'($signed(opb[k][n][WB-1:MUL_CHUNK*k]));
         end
         assign pp        = $signed(opa[k][n]) * chunk;
         assign acc_in[n] = acc[k][n] + (WP'(pp) << (MUL_CHUNK * k));
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (enable) begin
            vld_ff <= vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sid_ff <= sid[k];
            opa_ff <= opa[k];
            opb_ff <= opb[k];
            acc_ff <= acc_in;
         end
      end

      assign vld[k+1] = vld_ff;
      assign sid[k+1] = sid_ff;
      assign opa[k+1] = opa_ff;
      assign opb[k+1] = opb_ff;
      assign acc[k+1] = acc_ff;
   end

   assign out_valid = vld[NST];
   assign out_side  = sid[NST];
   assign out_p     = acc[NST];

endmodule

### hw/rtl/ssd_ratio.sv
// ----------------------------------------------------------------------------
// ssd_ratio
// Pipelined clamped ratio n/m in [0, 1] as unsigned fixed point with F
// fraction bits, one quotient bit per stage, rounded half up.
// ----------------------------------------------------------------------------
module ssd_ratio #(
   parameter int N  = 1,
   parameter int WQ = 137,
   parameter int F  = 16,
   parameter int WS = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [WS-1:0]         in_side,
   input  logic [N-1:0][WQ-1:0]  in_n,
   input  logic [N-1:0][WQ-1:0]  in_m,
   output logic                  out_valid,
   output logic [WS-1:0]         out_side,
   output logic [N-1:0][F:0]     out_q
);

   localparam int NS = F + 2;

   logic                 vld [NS+1];
   logic [WS-1:0]        sid [NS+1];
   logic [N-1:0][WQ-1:0] rem [NS+1];
   logic [N-1:0][WQ-1:0] den [NS+1];
   logic [N-1:0][F:0]    quo [NS+1];
   logic [N-1:0]         zer [NS+1];
   logic [N-1:0]         one [NS+1];

   assign vld[0] = in_valid;
   assign sid[0] = in_side;
   assign rem[0] = in_n;
   assign den[0] = in_m;
   assign quo[0] = '0;
   assign zer[0] = '0;
   assign one[0] = '0;

   for (genvar j = 0; j < NS; j++) begin : g_stage
      logic                 vld_ff;
      logic [WS-1:0]        sid_ff;
      logic [N-1:0][WQ-1:0] rem_ff, rem_in;
      logic [N-1:0][WQ-1:0] den_ff;
      logic [N-1:0][F:0]    quo_ff, quo_in;
      logic [N-1:0]         zer_ff, zer_in;
      logic [N-1:0]         one_ff, one_in;

      for (genvar n = 0; n < N; n++) begin : g_lane
         if (j == 0) begin : g_setup
            assign zer_in[n] = ($signed(den[0][n]) <= 0) || ($signed(rem[0][n]) <= 0);
            assign one_in[n] = $signed(rem[0][n]) >= $signed(den[0][n]);
            assign rem_in[n] = rem[0][n];
            assign quo_in[n] = '0;
         end else if (j <= F) begin : g_bit
            logic [WQ-1:0] sh;
            logic          ge;
            assign sh        = {rem[j][n][WQ-2:0], 1'b0};
            assign ge        = sh >= den[j][n];
            assign rem_in[n] = ge ? (sh - den[j][n]) : sh;
            assign quo_in[n] = {quo[j][n][F-1:0], ge};
            assign zer_in[n] = zer[j][n];
            assign one_in[n] = one[j][n];
         end else begin : g_round
            logic [WQ-1:0] sh;
            assign sh        = {rem[j][n][WQ-2:0], 1'b0};
            assign rem_in[n] = sh;
            assign quo_in[n] = quo[j][n] + (F+1)'(sh >= den[j][n]);
            assign zer_in[n] = zer[j][n];
            assign one_in[n] = one[j][n];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (enable) begin
            vld_ff <= vld[j];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            sid_ff <= sid[j];
            rem_ff <= rem_in;
            den_ff <= den[j];
            quo_ff <= quo_in;
            zer_ff <= zer_in;
            one_ff <= one_in;
         end
      end

      assign vld[j+1] = vld_ff;
      assign sid[j+1] = sid_ff;
      assign rem[j+1] = rem_ff;
      assign den[j+1] = den_ff;
      assign quo[j+1] = quo_ff;
      assign zer[j+1] = zer_ff;
      assign one[j+1] = one_ff;
   end

   assign out_valid = vld[NS];
   assign out_side  = sid[NS];

   for (genvar n = 0; n < N; n++) begin : g_out
      assign out_q[n] = zer[NS][n] ? '0 :
                        one[NS][n] ? ((F+1)'(1) << F) : quo[NS][n];
   end

endmodule

### hw/rtl/segment_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// segment_segment_distance_3d
// Closest distance between two 3D segments with the clamped parameters of the
// closest points, integer arithmetic throughout.
//
// req channel: one transaction carries both endpoints of both segments,
// signed Q16.16 (low COORD_WIDTH bits used). rsp channel: one transaction
// per request with the distance (Q17.16, rounded down) and the parameters
// s and t (Q1.PARAM_FRAC_BITS, 0 to 1).
// Throughput: one transaction per cycle while no stall holds the pipeline.
// The pipeline stages include the partial product multipliers, the
// bit-per-stage ratio unit and the bit-per-stage square root.
// The whole pipeline advances together; when rsp_ready is low with a result
// pending, every stage holds and req_ready drops, nothing is lost or repeated.
// Reset clears all valid bits; the block accepts on the first cycle after.
// ----------------------------------------------------------------------------
module segment_segment_distance_3d #(
   parameter int COORD_WIDTH     = ssd_pkg::COORD_WIDTH_DEF,
   parameter int PARAM_FRAC_BITS = ssd_pkg::PARAM_FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssd_pkg::rsp_type rsp_data
);
   import ssd_pkg::*;

   localparam int F  = PARAM_FRAC_BITS;
   localparam int DW = COORD_WIDTH + 1;
   localparam int AW = 2 * DW + 2;
   localparam int QW = 2 * AW + 1;
   localparam int GW = DW + F + 3;
   localparam int UW = DW + F + 2;
   localparam int QS = 2 * GW + 2;
   localparam int RB = (QS + 1) / 2;
   localparam int TW = 2 * RB + 1;
   localparam logic [F:0] PARAM_ONE = (F+1)'(1) << F;

   logic advance;

   // Input: differences
   logic [2:0][DW-1:0] p0, p1, q0, q1;
   logic [8:0][DW-1:0] uvw_in;
   logic               s1_vld_ff;
   logic [8:0][DW-1:0] s1_uvw_ff;

   assign p0[0] = DW'($signed(req_data.first_start_x[COORD_WIDTH-1:0]));
   assign p0[1] = DW'($signed(req_data.first_start_y[COORD_WIDTH-1:0]));
   assign p0[2] = DW'($signed(req_data.first_start_z[COORD_WIDTH-1:0]));
   assign p1[0] = DW'($signed(req_data.first_end_x[COORD_WIDTH-1:0]));
   assign p1[1] = DW'($signed(req_data.first_end_y[COORD_WIDTH-1:0]));
   assign p1[2] = DW'($signed(req_data.first_end_z[COORD_WIDTH-1:0]));
   assign q0[0] = DW'($signed(req_data.second_start_x[COORD_WIDTH-1:0]));
   assign q0[1] = DW'($signed(req_data.second_start_y[COORD_WIDTH-1:0]));
   assign q0[2] = DW'($signed(req_data.second_start_z[COORD_WIDTH-1:0]));
   assign q1[0] = DW'($signed(req_data.second_end_x[COORD_WIDTH-1:0]));
   assign q1[1] = DW'($signed(req_data.second_end_y[COORD_WIDTH-1:0]));
   assign q1[2] = DW'($signed(req_data.second_end_z[COORD_WIDTH-1:0]));

   for (genvar i = 0; i < 3; i++) begin : g_diff
      assign uvw_in[i]     = p1[i] - p0[i];
      assign uvw_in[3 + i] = q1[i] - q0[i];
      assign uvw_in[6 + i] = p0[i] - q0[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_uvw_ff <= uvw_in;
      end
   end

   // Dot product terms
   logic [14:0][DW-1:0]   m1_a, m1_b;
   logic                  m1_vld;
   logic [9*DW-1:0]       m1_side;
   logic [14:0][2*DW-1:0] m1_p;

   for (genvar i = 0; i < 3; i++) begin : g_m1
      assign m1_a[i]      = s1_uvw_ff[i];
      assign m1_b[i]      = s1_uvw_ff[i];
      assign m1_a[3 + i]  = s1_uvw_ff[i];
      assign m1_b[3 + i]  = s1_uvw_ff[3 + i];
      assign m1_a[6 + i]  = s1_uvw_ff[3 + i];
      assign m1_b[6 + i]  = s1_uvw_ff[3 + i];
      assign m1_a[9 + i]  = s1_uvw_ff[i];
      assign m1_b[9 + i]  = s1_uvw_ff[6 + i];
      assign m1_a[12 + i] = s1_uvw_ff[3 + i];
      assign m1_b[12 + i] = s1_uvw_ff[6 + i];
   end

   ssd_mul #(.N(15), .WA(DW), .WB(DW), .WS(9*DW)) u_mul_dot (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s1_vld_ff),
      .in_side   (s1_uvw_ff),
      .in_a      (m1_a),
      .in_b      (m1_b),
      .out_valid (m1_vld),
      .out_side  (m1_side),
      .out_p     (m1_p)
   );

   // Dot products a, b, c, d, e
   logic [4:0][AW-1:0] dot_in;
   logic               s2_vld_ff;
   logic [4:0][AW-1:0] s2_dot_ff;
   logic [9*DW-1:0]    s2_uvw_ff;

   for (genvar j = 0; j < 5; j++) begin : g_dot
      assign dot_in[j] = AW'($signed(m1_p[3*j]))
                       + AW'($signed(m1_p[3*j + 1]))
                       + AW'($signed(m1_p[3*j + 2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= m1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_dot_ff <= dot_in;
         s2_uvw_ff <= m1_side;
      end
   end

   // Cross products of the dot products
   logic [5:0][AW-1:0]   m2_a, m2_b;
   logic                 m2_vld;
   logic [5*AW+9*DW-1:0] m2_side;
   logic [5:0][2*AW-1:0] m2_p;

   assign m2_a[0] = s2_dot_ff[0];  assign m2_b[0] = s2_dot_ff[2];
   assign m2_a[1] = s2_dot_ff[1];  assign m2_b[1] = s2_dot_ff[1];
   assign m2_a[2] = s2_dot_ff[1];  assign m2_b[2] = s2_dot_ff[4];
   assign m2_a[3] = s2_dot_ff[2];  assign m2_b[3] = s2_dot_ff[3];
   assign m2_a[4] = s2_dot_ff[0];  assign m2_b[4] = s2_dot_ff[4];
   assign m2_a[5] = s2_dot_ff[1];  assign m2_b[5] = s2_dot_ff[3];

   ssd_mul #(.N(6), .WA(AW), .WB(AW), .WS(5*AW+9*DW)) u_mul_cross (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s2_vld_ff),
      .in_side   ({s2_dot_ff, s2_uvw_ff}),
      .in_a      (m2_a),
      .in_b      (m2_b),
      .out_valid (m2_vld),
      .out_side  (m2_side),
      .out_p     (m2_p)
   );

   // Determinant and unclamped numerators
   logic                  s3_vld_ff;
   logic signed [QW-1:0]  s3_dd_ff, s3_sn_ff, s3_tn_ff;
   logic [4:0][AW-1:0]    s3_dot_ff;
   logic [9*DW-1:0]       s3_uvw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= m2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_dd_ff  <= QW'($signed(m2_p[0])) - QW'($signed(m2_p[1]));
         s3_sn_ff  <= QW'($signed(m2_p[2])) - QW'($signed(m2_p[3]));
         s3_tn_ff  <= QW'($signed(m2_p[4])) - QW'($signed(m2_p[5]));
         s3_dot_ff <= m2_side[9*DW +: 5*AW];
         s3_uvw_ff <= m2_side[0 +: 9*DW];
      end
   end

   // First clamp: s against its edges
   logic signed [QW-1:0] c4_sn, c4_sd, c4_tn, c4_td;
   logic signed [QW-1:0] c4_e, c4_c, c4_eb;
   logic                 s4_vld_ff;
   logic signed [QW-1:0] s4_sn_ff, s4_sd_ff, s4_tn_ff, s4_td_ff;
   logic [4:0][AW-1:0]   s4_dot_ff;
   logic [9*DW-1:0]      s4_uvw_ff;

   assign c4_e  = QW'($signed(s3_dot_ff[4]));
   assign c4_c  = QW'($signed(s3_dot_ff[2]));
   assign c4_eb = c4_e + QW'($signed(s3_dot_ff[1]));

   always_comb begin
      if (s3_dd_ff <= 0) begin
         c4_sn = '0;
         c4_sd = QW'(1);
         c4_tn = c4_e;
         c4_td = c4_c;
      end else if (s3_sn_ff < 0) begin
         c4_sn = '0;
         c4_sd = s3_dd_ff;
         c4_tn = c4_e;
         c4_td = c4_c;
      end else if (s3_sn_ff > s3_dd_ff) begin
         c4_sn = s3_dd_ff;
         c4_sd = s3_dd_ff;
         c4_tn = c4_eb;
         c4_td = c4_c;
      end else begin
         c4_sn = s3_sn_ff;
         c4_sd = s3_dd_ff;
         c4_tn = s3_tn_ff;
         c4_td = s3_dd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_sn_ff  <= c4_sn;
         s4_sd_ff  <= c4_sd;
         s4_tn_ff  <= c4_tn;
         s4_td_ff  <= c4_td;
         s4_dot_ff <= s3_dot_ff;
         s4_uvw_ff <= s3_uvw_ff;
      end
   end

   // Second clamp: t against its edges, then point segments
   logic signed [QW-1:0] c5_a, c5_c, c5_e, c5_xn, c5_xb, c5_x;
   logic                 c5_tneg, c5_tbig;
   logic signed [QW-1:0] c5_sn, c5_sd, c5_tn, c5_td;
   logic [1:0][QW-1:0]   c5_n, c5_m;
   logic                 s5_vld_ff;
   logic [1:0][QW-1:0]   s5_n_ff, s5_m_ff;
   logic [9*DW-1:0]      s5_uvw_ff;

   assign c5_a    = QW'($signed(s4_dot_ff[0]));
   assign c5_c    = QW'($signed(s4_dot_ff[2]));
   assign c5_e    = QW'($signed(s4_dot_ff[4]));
   assign c5_xn   = -QW'($signed(s4_dot_ff[3]));
   assign c5_xb   = QW'($signed(s4_dot_ff[1])) - QW'($signed(s4_dot_ff[3]));
   assign c5_tneg = s4_tn_ff < 0;
   assign c5_tbig = s4_tn_ff > s4_td_ff;
   assign c5_x    = c5_tneg ? c5_xn : c5_xb;

   always_comb begin
      c5_sn = s4_sn_ff;
      c5_sd = s4_sd_ff;
      c5_tn = s4_tn_ff;
      c5_td = s4_td_ff;
      if (c5_tneg || c5_tbig) begin
         c5_tn = c5_tneg ? '0 : s4_td_ff;
         if (c5_x < 0) begin
            c5_sn = '0;
         end else if (c5_x > c5_a) begin
            c5_sn = s4_sd_ff;
         end else begin
            c5_sn = c5_x;
            c5_sd = c5_a;
         end
      end
      priority if (c5_a == 0 && c5_c == 0) begin
         c5_n = '0;
         c5_m = {QW'(1), QW'(1)};
      end else if (c5_a == 0) begin
         c5_n = {c5_e, QW'(0)};
         c5_m = {c5_c, QW'(1)};
      end else if (c5_c == 0) begin
         c5_n = {QW'(0), c5_xn};
         c5_m = {QW'(1), c5_a};
      end else begin
         c5_n = {c5_tn, c5_sn};
         c5_m = {c5_td, c5_sd};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (advance) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_n_ff   <= c5_n;
         s5_m_ff   <= c5_m;
         s5_uvw_ff <= s4_uvw_ff;
      end
   end

   // Parameters s and t
   logic               r_vld;
   logic [8:0][DW-1:0] r_uvw;
   logic [1:0][F:0]    r_q;

   ssd_ratio #(.N(2), .WQ(QW), .F(F), .WS(9*DW)) u_ratio (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s5_vld_ff),
      .in_side   (s5_uvw_ff),
      .in_n      (s5_n_ff),
      .in_m      (s5_m_ff),
      .out_valid (r_vld),
      .out_side  (r_uvw),
      .out_q     (r_q)
   );

   // Gap vector terms
   logic                s6_vld_ff;
   logic [2:0][UW-1:0]  s6_us_ff, s6_vt_ff;
   logic [2:0][DW-1:0]  s6_w_ff;
   logic [F:0]          s6_s_ff, s6_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else if (advance) begin
         s6_vld_ff <= r_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            s6_us_ff[i] <= UW'($signed(r_uvw[i])) * UW'($signed({1'b0, r_q[0]}));
            s6_vt_ff[i] <= UW'($signed(r_uvw[3 + i])) * UW'($signed({1'b0, r_q[1]}));
            s6_w_ff[i]  <= r_uvw[6 + i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_s_ff <= r_q[0];
         s6_t_ff <= r_q[1];
      end
   end

   // Gap vector
   logic               s7_vld_ff;
   logic [2:0][GW-1:0] s7_g_ff;
   logic [F:0]         s7_s_ff, s7_t_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
      end else if (advance) begin
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            s7_g_ff[i] <= (GW'($signed(s6_w_ff[i])) << F)
                        + GW'($signed(s6_us_ff[i])) - GW'($signed(s6_vt_ff[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_s_ff <= s6_s_ff;
         s7_t_ff <= s6_t_ff;
      end
   end

   // Squared gap components
   logic                 m3_vld;
   logic [2*F+1:0]       m3_side;
   logic [2:0][2*GW-1:0] m3_p;

   ssd_mul #(.N(3), .WA(GW), .WB(GW), .WS(2*F+2)) u_mul_square (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (s7_vld_ff),
      .in_side   ({s7_s_ff, s7_t_ff}),
      .in_a      (s7_g_ff),
      .in_b      (s7_g_ff),
      .out_valid (m3_vld),
      .out_side  (m3_side),
      .out_p     (m3_p)
   );

   // Squared distance, then square root one bit per stage
   logic            sq_vld  [RB+1];
   logic [TW-1:0]   sq_rem  [RB+1];
   logic [RB-1:0]   sq_root [RB+1];
   logic [2*F+1:0]  sq_st   [RB+1];
   logic            s8_vld_ff;
   logic [QS-1:0]   s8_sum_ff;
   logic [2*F+1:0]  s8_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_vld_ff <= 1'b0;
      end else if (advance) begin
         s8_vld_ff <= m3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s8_sum_ff <= QS'($signed(m3_p[0])) + QS'($signed(m3_p[1]))
                    + QS'($signed(m3_p[2]));
         s8_st_ff  <= m3_side;
      end
   end

   assign sq_vld[0]  = s8_vld_ff;
   assign sq_rem[0]  = TW'(s8_sum_ff);
   assign sq_root[0] = '0;
   assign sq_st[0]   = s8_st_ff;

   for (genvar j = 0; j < RB; j++) begin : g_sqrt
      localparam int K = RB - 1 - j;
      logic            vld_ff;
      logic [TW-1:0]   rem_ff;
      logic [RB-1:0]   root_ff;
      logic [2*F+1:0]  st_ff;
      logic [TW-1:0]   trial;
      logic            take;

      assign trial = (TW'(sq_root[j]) << (K + 1)) | (TW'(1) << (2 * K));
      assign take  = trial <= sq_rem[j];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (advance) begin
            vld_ff <= sq_vld[j];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff  <= take ? (sq_rem[j] - trial) : sq_rem[j];
            root_ff <= take ? (sq_root[j] | (RB'(1) << K)) : sq_root[j];
            st_ff   <= sq_st[j];
         end
      end

      assign sq_vld[j+1]  = vld_ff;
      assign sq_rem[j+1]  = rem_ff;
      assign sq_root[j+1] = root_ff;
      assign sq_st[j+1]   = st_ff;
   end

   // Output
   logic [F:0] out_s, out_t;

   assign out_s     = sq_st[RB][2*F+1:F+1];
   assign out_t     = sq_st[RB][F:0];
   assign rsp_valid = sq_vld[RB];
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign rsp_data.closest_distance = DIST_WIDTH'(sq_root[RB] >> F);
   assign rsp_data.first_param      = PARAM_WIDTH'(out_s);
   assign rsp_data.second_param     = PARAM_WIDTH'(out_t);

   a_s_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_s <= PARAM_ONE)
      else $error("first parameter above one");

   a_t_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_t <= PARAM_ONE)
      else $error("second parameter above one");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_vld_ff)
      else $error("valid bits survive reset");

   a_hold_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input held without a pending transaction");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sq_root[RB]) && $stable(s1_uvw_ff))
      else $error("pipeline moved during stall");

endmodule
